@@ rtl/core/roi_pkg.sv @@
// Shared types, constants and codes for the radial offset interpolator.
package roi_pkg;

	localparam int DEF_MAX_POINTS = 64;
	localparam int POS_W          = 24;
	localparam int OFF_W          = 16;
	localparam int D2_W           = 50;
	localparam int WQ_W           = 16;
	localparam int CNT_OUT_W      = 7;
	localparam int POS_MAX        = 8388607;
	localparam int POS_MIN        = -8388608;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// One table entry: key position and correction offset per axis
	typedef struct packed {
		logic [2:0][POS_W-1:0] key;
		logic [2:0][OFF_W-1:0] corr;
	} roi_entry_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       cap;
		logic       rd;
		logic       wr;
		logic       sq_en;
		logic       sq_clr;
		logic       sq_rad;
		logic       wd_init;
		logic       wd_step;
		logic       mul_en;
		logic       n_inc;
		logic       fd_init;
		logic       fd_step;
		logic       fin_en;
		logic       res_ins;
		logic       res_drop;
		logic       res_none;
		logic       res_q;
		logic [1:0] axis;
	} roi_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic kind;
		logic at_end;
		logic full;
		logic fill_zero;
		logic match;
		logic d2_lt;
		logic d2_zero;
		logic n_zero;
	} roi_sts_t;

endpackage

@@ rtl/core/roi_dp.sv @@
// Datapath: point table, squared distance, weight divider, accumulators, final divide.
module roi_dp import roi_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  roi_cmd_t                     cmd,
	input  logic [$clog2(MAX_POINTS+1)-1:0] idx,
	output roi_sts_t                     sts,
	input  logic                         kind,
	input  logic signed [POS_W-1:0]      pos_x,
	input  logic signed [POS_W-1:0]      pos_y,
	input  logic signed [POS_W-1:0]      pos_z,
	input  logic signed [OFF_W-1:0]      off_x,
	input  logic signed [OFF_W-1:0]      off_y,
	input  logic signed [OFF_W-1:0]      off_z,
	output logic                         done,
	output logic signed [POS_W-1:0]      out_x,
	output logic signed [POS_W-1:0]      out_y,
	output logic signed [POS_W-1:0]      out_z,
	output logic [CNT_OUT_W-1:0]         neighbour_count,
	output logic [1:0]                   status
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS+1);
	localparam int SW = CW + 33;
	localparam int QW = SW - 16;
	localparam int FW = POS_W + 2;
	localparam int PW = WQ_W + OFF_W + 1;

	// Captured input word
	logic                    kind_q;
	logic [2:0][POS_W-1:0]   pos_q;
	logic [2:0][OFF_W-1:0]   off_q;

	// Table memory and registered read port
	roi_entry_t mem [MAX_POINTS];
	roi_entry_t rdata_q;

	logic [CW-1:0]   fill_q;
	logic [D2_W-1:0] radius_q;
	logic [D2_W-1:0] d2_q;
	logic [D2_W-1:0] wrem_q;
	logic [WQ_W-1:0] wquo_q;
	logic            wzero_q;
	logic [CW-1:0]   n_q;
	logic signed [SW-1:0] acc_q [3];
	logic [CW-1:0]   frem_q;
	logic [QW-1:0]   fquo_q;
	logic            fneg_q;
	logic [2:0][POS_W-1:0] res_pos_q;
	logic [CNT_OUT_W-1:0]  cnt_q;
	logic [1:0]            st_q;
	logic                  done_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q <= kind;
			pos_q  <= {pos_z, pos_y, pos_x};
			off_q  <= {off_z, off_y, off_x};
		end
	end

	// Memory write and read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[idx[AW-1:0]] <= '{key: pos_q, corr: off_q};
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx[AW-1:0]];
		end
	end

	// Fill count and radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			radius_q <= '0;
		end else if (cmd.wr && (idx == fill_q)) begin
			fill_q <= fill_q + 1'b1;
			if (fill_q == '0) begin
				radius_q <= d2_q;
			end
		end
	end

	// Squaring unit, one axis per cycle
	logic signed [POS_W:0] sq_diff;
	logic [POS_W:0]        sq_mag;
	logic [D2_W-1:0]       sq_val;
	always_comb begin
		sq_diff = {pos_q[cmd.axis][POS_W-1], pos_q[cmd.axis]}
			- (cmd.sq_rad ? '0 : {rdata_q.key[cmd.axis][POS_W-1], rdata_q.key[cmd.axis]});
		sq_mag  = sq_diff[POS_W] ? (POS_W+1)'(-sq_diff) : sq_diff;
		sq_val  = D2_W'(sq_mag * sq_mag);
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			d2_q <= (cmd.sq_clr ? '0 : d2_q) + sq_val;
		end
	end

	// Weight divider: one quotient bit per cycle
	logic [D2_W:0] wd_t;
	assign wd_t = {wrem_q, 1'b0};
	always_ff @(posedge clk) begin
		if (cmd.wd_init) begin
			wrem_q  <= radius_q - d2_q;
			wquo_q  <= '0;
			wzero_q <= (d2_q == '0);
		end else if (cmd.wd_step) begin
			if (wd_t >= {1'b0, radius_q}) begin
				wrem_q <= D2_W'(wd_t - {1'b0, radius_q});
				wquo_q <= {wquo_q[WQ_W-2:0], 1'b1};
			end else begin
				wrem_q <= D2_W'(wd_t);
				wquo_q <= {wquo_q[WQ_W-2:0], 1'b0};
			end
		end
	end

	// Weighted offset product
	logic [WQ_W:0]          weight;
	logic signed [PW-1:0]   prod;
	assign weight = wzero_q ? {1'b1, {WQ_W{1'b0}}} : {1'b0, wquo_q};
	assign prod   = PW'($signed({1'b0, weight}) * $signed(rdata_q.corr[cmd.axis]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cmd.cap) begin
			n_q <= '0;
		end else if (cmd.n_inc) begin
			n_q <= n_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			for (int a = 0; a < 3; a++) acc_q[a] <= '0;
		end else if (cmd.mul_en) begin
			acc_q[cmd.axis] <= acc_q[cmd.axis] + {{(SW-PW){prod[PW-1]}}, prod};
		end
	end

	// Final divide of |S| >> 16 by the neighbour count
	logic signed [SW-1:0] fsel;
	logic [SW-1:0]        fmag;
	logic [CW:0]          fd_t;
	assign fsel = acc_q[cmd.axis];
	assign fmag = fsel[SW-1] ? SW'(-fsel) : fsel;
	assign fd_t = {frem_q, fquo_q[QW-1]};

	always_ff @(posedge clk) begin
		if (cmd.fd_init) begin
			frem_q <= '0;
			fquo_q <= fmag[SW-1:16];
			fneg_q <= fsel[SW-1];
		end else if (cmd.fd_step) begin
			if (fd_t >= {1'b0, n_q}) begin
				frem_q <= CW'(fd_t - {1'b0, n_q});
				fquo_q <= {fquo_q[QW-2:0], 1'b1};
			end else begin
				frem_q <= CW'(fd_t);
				fquo_q <= {fquo_q[QW-2:0], 1'b0};
			end
		end
	end

	// Add correction to position and saturate
	logic signed [FW-1:0] fcor;
	logic signed [FW-1:0] fsum;
	logic [POS_W-1:0]     fsat;
	always_comb begin
		fcor = fneg_q ? -$signed(FW'(fquo_q)) : $signed(FW'(fquo_q));
		fsum = $signed({{(FW-POS_W){pos_q[cmd.axis][POS_W-1]}}, pos_q[cmd.axis]}) + fcor;
		if (fsum > $signed(FW'(POS_MAX))) begin
			fsat = POS_W'(POS_MAX);
		end else if (fsum < $signed(FW'(POS_MIN))) begin
			fsat = POS_W'(POS_MIN);
		end else begin
			fsat = fsum[POS_W-1:0];
		end
	end

	// Result registers
	logic [CW+CNT_OUT_W-1:0] fill_ext;
	logic [CW+CNT_OUT_W-1:0] n_ext;
	assign fill_ext = {{CNT_OUT_W{1'b0}}, fill_q};
	assign n_ext    = {{CNT_OUT_W{1'b0}}, n_q};

	always_ff @(posedge clk) begin
		if (cmd.fin_en) begin
			res_pos_q[cmd.axis] <= fsat;
		end
		if (cmd.res_ins) begin
			res_pos_q <= '0;
			cnt_q     <= fill_ext[CNT_OUT_W-1:0];
			st_q      <= cmd.res_drop ? ST_FULL : ST_OK;
		end
		if (cmd.res_none) begin
			res_pos_q <= pos_q;
			cnt_q     <= '0;
			st_q      <= ST_NONE;
		end
		if (cmd.res_q) begin
			cnt_q <= n_ext[CNT_OUT_W-1:0];
			st_q  <= ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_ins | cmd.res_none | cmd.res_q;
		end
	end

	assign done            = done_q;
	assign out_x           = res_pos_q[0];
	assign out_y           = res_pos_q[1];
	assign out_z           = res_pos_q[2];
	assign neighbour_count = cnt_q;
	assign status          = st_q;

	// Status toward the controller
	always_comb begin
		sts.kind      = kind_q;
		sts.at_end    = (idx >= fill_q);
		sts.full      = (fill_q == CW'(MAX_POINTS));
		sts.fill_zero = (fill_q == '0);
		sts.match     = (rdata_q.key == pos_q);
		sts.d2_lt     = (d2_q < radius_q);
		sts.d2_zero   = (d2_q == '0);
		sts.n_zero    = (n_q == '0);
	end

endmodule

@@ rtl/core/roi_ctrl.sv @@
// Controller: sequences table walks, divider steps and result delivery.
module roi_ctrl import roi_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  roi_sts_t                        sts,
	output roi_cmd_t                        cmd,
	output logic [$clog2(MAX_POINTS+1)-1:0] idx
);

	localparam int CW  = $clog2(MAX_POINTS+1);
	localparam int QW  = CW + 17;
	localparam int SCW = $clog2(QW+1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_IRD   = 4'd2;
	localparam logic [3:0] S_ICMP  = 4'd3;
	localparam logic [3:0] S_IRAD  = 4'd4;
	localparam logic [3:0] S_IWR   = 4'd5;
	localparam logic [3:0] S_IRES  = 4'd6;
	localparam logic [3:0] S_QRD   = 4'd7;
	localparam logic [3:0] S_QSQ   = 4'd8;
	localparam logic [3:0] S_QCHK  = 4'd9;
	localparam logic [3:0] S_QDIV  = 4'd10;
	localparam logic [3:0] S_QMUL  = 4'd11;
	localparam logic [3:0] S_FINIT = 4'd12;
	localparam logic [3:0] S_FDIV  = 4'd13;
	localparam logic [3:0] S_FFIN  = 4'd14;

	logic [3:0]     state_q, state_d;
	logic [CW-1:0]  idx_q, idx_d;
	logic [SCW-1:0] step_q, step_d;
	logic [1:0]     axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
			axis_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			step_q  <= step_d;
			axis_q  <= axis_d;
		end
	end

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		step_d  = step_q;
		axis_d  = axis_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					idx_d   = '0;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = (sts.kind == KIND_QUERY) ? S_QRD : S_IRD;
			end
			S_IRD: begin
				if (sts.at_end) begin
					if (sts.full) begin
						cmd.res_ins  = 1'b1;
						cmd.res_drop = 1'b1;
						state_d      = S_IDLE;
					end else if (sts.fill_zero) begin
						step_d  = '0;
						state_d = S_IRAD;
					end else begin
						state_d = S_IWR;
					end
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_ICMP;
				end
			end
			S_ICMP: begin
				if (sts.match) begin
					state_d = S_IWR;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_IRD;
				end
			end
			S_IRAD: begin
				cmd.sq_en  = 1'b1;
				cmd.sq_rad = 1'b1;
				cmd.sq_clr = (step_q == '0);
				cmd.axis   = step_q[1:0];
				step_d     = step_q + 1'b1;
				if (step_q == SCW'(2)) begin
					state_d = S_IWR;
				end
			end
			S_IWR: begin
				cmd.wr  = 1'b1;
				state_d = S_IRES;
			end
			S_IRES: begin
				cmd.res_ins = 1'b1;
				state_d     = S_IDLE;
			end
			S_QRD: begin
				if (sts.at_end) begin
					if (sts.n_zero) begin
						cmd.res_none = 1'b1;
						state_d      = S_IDLE;
					end else begin
						axis_d  = '0;
						state_d = S_FINIT;
					end
				end else begin
					cmd.rd  = 1'b1;
					step_d  = '0;
					state_d = S_QSQ;
				end
			end
			S_QSQ: begin
				cmd.sq_en  = 1'b1;
				cmd.sq_clr = (step_q == '0);
				cmd.axis   = step_q[1:0];
				step_d     = step_q + 1'b1;
				if (step_q == SCW'(2)) begin
					state_d = S_QCHK;
				end
			end
			S_QCHK: begin
				step_d = '0;
				if (sts.d2_lt) begin
					cmd.wd_init = 1'b1;
					state_d     = sts.d2_zero ? S_QMUL : S_QDIV;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_QRD;
				end
			end
			S_QDIV: begin
				cmd.wd_step = 1'b1;
				step_d      = step_q + 1'b1;
				if (step_q == SCW'(WQ_W-1)) begin
					step_d  = '0;
					state_d = S_QMUL;
				end
			end
			S_QMUL: begin
				cmd.mul_en = 1'b1;
				cmd.axis   = step_q[1:0];
				step_d     = step_q + 1'b1;
				if (step_q == SCW'(2)) begin
					cmd.n_inc = 1'b1;
					idx_d     = idx_q + 1'b1;
					state_d   = S_QRD;
				end
			end
			S_FINIT: begin
				cmd.fd_init = 1'b1;
				cmd.axis    = axis_q;
				step_d      = '0;
				state_d     = S_FDIV;
			end
			S_FDIV: begin
				cmd.fd_step = 1'b1;
				cmd.axis    = axis_q;
				step_d      = step_q + 1'b1;
				if (step_q == SCW'(QW-1)) begin
					state_d = S_FFIN;
				end
			end
			S_FFIN: begin
				cmd.fin_en = 1'b1;
				cmd.axis   = axis_q;
				if (axis_q == 2'd2) begin
					cmd.res_q = 1'b1;
					state_d   = S_IDLE;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = S_FINIT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign idx  = idx_q;

endmodule

@@ rtl/core/radial_offset_interpolator_unit.sv @@
// Top level: radial offset interpolator with calibration table.
// Insert: searches the table entry by entry for the key, then writes (radius set on the first entry).
// Query: squared distance for each entry, then for each neighbour inside the radius the 16-step
// weight divider (skipped on an exact hit) and a multiply-accumulate, plus the per-axis count divide;
// default table of 64 entries. One word at a time; done pulses once.
// Async reset empties the table (fill count and radius cleared); receiver cannot stall.
module radial_offset_interpolator_unit import roi_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    kind,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic signed [OFF_W-1:0] off_x,
	input  logic signed [OFF_W-1:0] off_y,
	input  logic signed [OFF_W-1:0] off_z,
	output logic                    done,
	output logic signed [POS_W-1:0] out_x,
	output logic signed [POS_W-1:0] out_y,
	output logic signed [POS_W-1:0] out_z,
	output logic [CNT_OUT_W-1:0]    neighbour_count,
	output logic [1:0]              status
);

	localparam int CW = $clog2(MAX_POINTS+1);

	roi_cmd_t      cmd;
	roi_sts_t      sts;
	logic [CW-1:0] idx;
	logic          start_ok;

	assign start_ok = start & ~busy;

	roi_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ok),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd),
		.idx    (idx)
	);

	roi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.idx             (idx),
		.sts             (sts),
		.kind            (kind),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.off_x           (off_x),
		.off_y           (off_y),
		.off_z           (off_z),
		.done            (done),
		.out_x           (out_x),
		.out_y           (out_y),
		.out_z           (out_z),
		.neighbour_count (neighbour_count),
		.status          (status)
	);

endmodule

@@ sim/testbench.sv @@
// Testbench for the radial offset interpolator: directed and random insert/query words.
`timescale 1ns / 100ps

module testbench;
	import roi_pkg::*;

	localparam int TABLE_DEPTH = DEF_MAX_POINTS;
	localparam int STALL_LIMIT = 50000;

	typedef struct {
		logic                    kind;
		logic signed [POS_W-1:0] px, py, pz;
		logic signed [OFF_W-1:0] ox, oy, oz;
	} word_t;

	typedef struct {
		logic signed [POS_W-1:0] x, y, z;
		logic [CNT_OUT_W-1:0]    cnt;
		logic [1:0]              st;
	} corr_pos_t;

	// Calibration table model plus queue of predicted corrected positions
	class offset_scoreboard;
		longint    key_x[TABLE_DEPTH], key_y[TABLE_DEPTH], key_z[TABLE_DEPTH];
		longint    cor_x[TABLE_DEPTH], cor_y[TABLE_DEPTH], cor_z[TABLE_DEPTH];
		int        fill;
		longint    rad_sq;
		corr_pos_t pending_pos[$];
		int        errors, n_ins, n_qry, n_full, n_none, n_results;

		function new();
			fill   = 0;
			rad_sq = 0;
		endfunction

		function longint sq(longint d);
			return d * d;
		endfunction

		// Q1.16 weight by restoring division, exactly 1.0 on a direct hit
		function longint weight(longint d2, longint r2);
			longint rem;
			longint q;
			rem = r2 - d2;
			q   = 0;
			if (d2 == 0)
				return 65536;
			for (int i = 0; i < 16; i++) begin
				rem = rem << 1;
				q   = q << 1;
				if (rem >= r2) begin
					rem = rem - r2;
					q   = q | 1;
				end
			end
			return q;
		endfunction

		function logic signed [POS_W-1:0] clip(longint v);
			if (v > POS_MAX) return POS_W'(POS_MAX);
			if (v < POS_MIN) return POS_W'(POS_MIN);
			return v[POS_W-1:0];
		endfunction

		function void note_word(word_t w);
			longint    px, py, pz, d2, wt, sx, sy, sz, n, den;
			int        slot;
			corr_pos_t e;
			px = w.px; py = w.py; pz = w.pz;
			e.x = '0; e.y = '0; e.z = '0;
			if (w.kind == KIND_INSERT) begin
				n_ins++;
				e.st = ST_OK;
				slot = fill;
				for (int i = 0; i < fill; i++)
					if (key_x[i] == px && key_y[i] == py && key_z[i] == pz) begin
						slot = i;
						break;
					end
				if (slot == fill) begin
					if (fill >= TABLE_DEPTH) begin
						e.st = ST_FULL;
						n_full++;
					end else begin
						if (fill == 0)
							rad_sq = sq(px) + sq(py) + sq(pz);
						key_x[slot] = px; key_y[slot] = py; key_z[slot] = pz;
						fill++;
					end
				end
				if (e.st == ST_OK) begin
					cor_x[slot] = w.ox; cor_y[slot] = w.oy; cor_z[slot] = w.oz;
				end
				e.cnt = fill[CNT_OUT_W-1:0];
			end else begin
				n_qry++;
				sx = 0; sy = 0; sz = 0; n = 0;
				for (int i = 0; i < fill; i++) begin
					d2 = sq(px - key_x[i]) + sq(py - key_y[i]) + sq(pz - key_z[i]);
					if (d2 < rad_sq) begin
						wt = weight(d2, rad_sq);
						sx += wt * cor_x[i];
						sy += wt * cor_y[i];
						sz += wt * cor_z[i];
						n++;
					end
				end
				if (n == 0) begin
					n_none++;
					e.x = w.px; e.y = w.py; e.z = w.pz;
					e.cnt = '0;
					e.st  = ST_NONE;
				end else begin
					den   = n * 65536;
					e.x   = clip(px + sx / den);
					e.y   = clip(py + sy / den);
					e.z   = clip(pz + sz / den);
					e.cnt = n[CNT_OUT_W-1:0];
					e.st  = ST_OK;
				end
			end
			pending_pos = {pending_pos, e};
		endfunction

		function void check_result(corr_pos_t a);
			corr_pos_t e;
			n_results++;
			if (pending_pos.size() == 0) begin
				$display("%0t: result with nothing expected: x=%0d y=%0d z=%0d cnt=%0d st=%0d",
					$time, a.x, a.y, a.z, a.cnt, a.st);
				errors++;
				return;
			end
			e = pending_pos.pop_front();
			if (a.x !== e.x) begin
				$display("%0t: out_x expected %0d actual %0d", $time, e.x, a.x);
				errors++;
			end
			if (a.y !== e.y) begin
				$display("%0t: out_y expected %0d actual %0d", $time, e.y, a.y);
				errors++;
			end
			if (a.z !== e.z) begin
				$display("%0t: out_z expected %0d actual %0d", $time, e.z, a.z);
				errors++;
			end
			if (a.cnt !== e.cnt) begin
				$display("%0t: neighbour_count expected %0d actual %0d", $time, e.cnt, a.cnt);
				errors++;
			end
			if (a.st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, a.st);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic                    kind = KIND_INSERT;
	logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [OFF_W-1:0] off_x = '0, off_y = '0, off_z = '0;
	logic                    done;
	logic signed [POS_W-1:0] out_x, out_y, out_z;
	logic [CNT_OUT_W-1:0]    neighbour_count;
	logic [1:0]              status;

	offset_scoreboard sb = new();
	int               stall_cycles = 0;

	radial_offset_interpolator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.off_x(off_x), .off_y(off_y), .off_z(off_z),
		.done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.neighbour_count(neighbour_count), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result monitor and stall watchdog
	always @(posedge clk) begin
		corr_pos_t a;
		if (arst_n) begin
			if (done) begin
				a.x = out_x; a.y = out_y; a.z = out_z;
				a.cnt = neighbour_count; a.st = status;
				sb.check_result(a);
			end
			if (done || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding",
					$time, sb.pending_pos.size());
				$display("** radial_offset_interpolator_unit: FAILED **");
				$finish;
			end
		end
	end

	// Present one word and hold it until the block takes it
	task automatic send_word(word_t w);
		start <= 1'b1;
		kind  <= w.kind;
		pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
		off_x <= w.ox; off_y <= w.oy; off_z <= w.oz;
		do @(posedge clk); while (busy);
		sb.note_word(w);
	endtask

	task automatic idle(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic word_t mk(logic k, int x, int y, int z, int a, int b, int c);
		word_t w;
		w.kind = k;
		w.px = POS_W'(x); w.py = POS_W'(y); w.pz = POS_W'(z);
		w.ox = OFF_W'(a); w.oy = OFF_W'(b); w.oz = OFF_W'(c);
		return w;
	endfunction

	function automatic int near_coord(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Keys on a coarse grid so repeated positions hit the replace path
	function automatic int grid_coord();
		return (int'($urandom_range(0, 8)) - 4) * 2048;
	endfunction

	initial begin
		word_t dir[$];
		word_t w;
		int    burst;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, radius set, replace, hits, far points, saturation
		dir = {dir, mk(KIND_QUERY, 100, -100, 5, 1, 2, 3)};
		dir = {dir, mk(KIND_INSERT, 4096, 4096, 4096, 256, -256, 32767)};
		dir = {dir, mk(KIND_QUERY, 4096, 4096, 4096, 0, 0, 0)};
		dir = {dir, mk(KIND_INSERT, 4096, 4096, 4096, -32768, 32767, 0)};
		dir = {dir, mk(KIND_QUERY, 4096, 4096, 4096, -1, -1, -1)};
		dir = {dir, mk(KIND_QUERY, 0, 0, 0, 0, 0, 0)};
		dir = {dir, mk(KIND_INSERT, 0, 0, 0, 1000, -1000, 5)};
		dir = {dir, mk(KIND_QUERY, 2048, 2048, 2048, 0, 0, 0)};
		dir = {dir, mk(KIND_QUERY, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0)};
		dir = {dir, mk(KIND_INSERT, POS_MAX, POS_MAX, POS_MAX, 32767, 32767, 32767)};
		dir = {dir, mk(KIND_QUERY, POS_MAX, POS_MAX, POS_MAX, 0, 0, 0)};
		dir = {dir, mk(KIND_INSERT, POS_MIN, POS_MIN, POS_MIN, -32768, -32768, -32768)};
		dir = {dir, mk(KIND_QUERY, POS_MIN, POS_MIN, POS_MIN, 32767, -32768, 1)};
		dir = {dir, mk(KIND_QUERY, POS_MAX - 1000, POS_MAX, POS_MAX - 50, 0, 0, 0)};
		dir = {dir, mk(KIND_INSERT, -4096, 0, 4096, 0, 0, 0)};
		dir = {dir, mk(KIND_QUERY, -2000, 100, 3000, 0, 0, 0)};
		dir = {dir, mk(KIND_QUERY, 0, POS_MAX, POS_MIN, 0, 0, 0)};
		foreach (dir[i])
			send_word(dir[i]);
		idle(3);

		// Random: mostly clustered inserts and queries, some full-range noise
		for (int i = 0; i < 400; ) begin
			burst = $urandom_range(1, 20);
			for (int j = 0; j < burst && i < 400; j++, i++) begin
				w.kind = 1'($urandom_range(0, 1));
				w.ox = OFF_W'($urandom); w.oy = OFF_W'($urandom); w.oz = OFF_W'($urandom);
				if ($urandom_range(0, 9) == 0) begin
					w.px = POS_W'($urandom); w.py = POS_W'($urandom); w.pz = POS_W'($urandom);
				end else if (w.kind == KIND_INSERT) begin
					w.px = POS_W'(grid_coord() + near_coord(2));
					w.py = POS_W'(grid_coord());
					w.pz = POS_W'(grid_coord() + near_coord(1));
				end else begin
					w.px = POS_W'(near_coord(9000));
					w.py = POS_W'(near_coord(9000));
					w.pz = POS_W'(near_coord(9000));
				end
				send_word(w);
				if (i == 200) begin
					start <= 1'b0;
					while (sb.pending_pos.size() != 0) @(posedge clk);
				end
			end
			if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 30));
		end
		start <= 1'b0;

		while (sb.pending_pos.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d inserts (%0d dropped on a full table, final fill %0d)",
			sb.n_ins, sb.n_full, sb.fill);
		$display("and %0d queries (%0d with no neighbours); %0d results, %0d mismatches",
			sb.n_qry, sb.n_none, sb.n_results, sb.errors);
		if (sb.errors == 0)
			$display("** radial_offset_interpolator_unit: PASSED **");
		else
			$display("** radial_offset_interpolator_unit: FAILED **");
		$finish;
	end

endmodule
